@@ rtl/cfts_pkg.sv @@
package cfts_pkg;

    localparam int FILTER_SLOTS_DEF = 16;
    localparam int TIME_BITS_DEF    = 32;
    localparam int ID_W             = 29;
    localparam int SLOT_W           = 4;
    localparam int TMO_W            = 32;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_RX     = 2'd1,
        CMD_SET    = 2'd2,
        CMD_REMOVE = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        EV_MATCH   = 2'd0,
        EV_PASS    = 2'd1,
        EV_TIMEOUT = 2'd2
    } ev_t;

    // Command token that walks the cell row, one cell per beat of the chain
    typedef struct packed {
        logic              active;
        cmd_t              cmd;
        logic [ID_W-1:0]   id;
        logic [ID_W-1:0]   mask;
        logic [SLOT_W-1:0] slot;
        logic [TMO_W-1:0]  tmo;
        logic              found;
        logic              any;
    } tok_t;

    typedef struct packed {
        logic              emit;
        ev_t               ev;
        logic [SLOT_W-1:0] hit_slot;
        logic [ID_W-1:0]   packet_id;
        logic              recovered;
    } res_t;

endpackage

@@ rtl/cfts_req_if.sv @@
interface cfts_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  cmd;
    logic [28:0] can_id;
    logic [28:0] filter_mask;
    logic [3:0]  slot;
    logic [31:0] timeout_ticks;

    modport source (output valid, cmd, can_id, filter_mask, slot, timeout_ticks,
                    input ready);
    modport sink   (input valid, cmd, can_id, filter_mask, slot, timeout_ticks,
                    output ready);
endinterface

@@ rtl/cfts_rsp_if.sv @@
interface cfts_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  event_res;
    logic [3:0]  hit_slot;
    logic [28:0] packet_id;
    logic        recovered;
    logic        last_event;

    modport source (output valid, event_res, hit_slot, packet_id, recovered, last_event,
                    input ready);
    modport sink   (input valid, event_res, hit_slot, packet_id, recovered, last_event,
                    output ready);
endinterface

@@ rtl/cfts_cell.sv @@
module cfts_cell #(
    parameter int IDX       = 0,
    parameter int TIME_BITS = cfts_pkg::TIME_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 adv,
    input  cfts_pkg::tok_t       tok_in,
    input  logic [TIME_BITS-1:0] time_in,
    output cfts_pkg::tok_t       tok_out,
    output logic [TIME_BITS-1:0] time_out,
    output cfts_pkg::res_t       res
);
    import cfts_pkg::*;

    localparam int CW = (TIME_BITS > TMO_W) ? TIME_BITS : TMO_W;

    logic                 valid_reg, valid_next;
    logic                 to_reg, to_next;
    logic [ID_W-1:0]      addr_reg;
    logic [ID_W-1:0]      mask_reg;
    logic [TMO_W-1:0]     tmo_reg;
    logic [TIME_BITS-1:0] seen_reg;
    tok_t                 tok_reg, tok_next;
    logic [TIME_BITS-1:0] time_reg;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired, match, sel, load, refresh;

    assign elapsed = time_in - seen_reg;
    assign expired = valid_reg && !to_reg && (CW'(elapsed) > CW'(tmo_reg));
    assign match   = ((tok_in.id & mask_reg) == (addr_reg & mask_reg));
    assign sel     = (int'(tok_in.slot) == IDX);

    always_comb
    begin
        tok_next   = tok_in;
        valid_next = valid_reg;
        to_next    = to_reg;
        load       = 1'b0;
        refresh    = 1'b0;
        res        = '0;
        res.hit_slot = SLOT_W'(IDX);
        if (tok_in.active)
        begin
            case (tok_in.cmd)
                CMD_TICK:
                begin
                    if (expired)
                    begin
                        to_next  = 1'b1;
                        res.emit = 1'b1;
                        res.ev   = EV_TIMEOUT;
                    end
                end
                CMD_RX:
                begin
                    if (valid_reg)
                    begin
                        tok_next.any = 1'b1;
                        if (!tok_in.found && match)
                        begin
                            res.emit       = 1'b1;
                            res.ev         = EV_MATCH;
                            res.packet_id  = tok_in.id;
                            res.recovered  = to_reg;
                            to_next        = 1'b0;
                            refresh        = 1'b1;
                            tok_next.found = 1'b1;
                        end
                    end
                end
                CMD_SET:
                begin
                    if (sel)
                    begin
                        valid_next = 1'b1;
                        to_next    = 1'b0;
                        load       = 1'b1;
                    end
                end
                CMD_REMOVE:
                begin
                    if (sel)
                    begin
                        valid_next = 1'b0;
                        to_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            to_reg    <= 1'b0;
            tok_reg   <= '0;
        end
        else if (adv)
        begin
            valid_reg <= valid_next;
            to_reg    <= to_next;
            tok_reg   <= tok_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            time_reg <= time_in;
            if (load)
            begin
                addr_reg <= tok_in.id;
                mask_reg <= tok_in.mask;
                tmo_reg  <= tok_in.tmo;
            end
            if (load || refresh)
            begin
                seen_reg <= time_in;
            end
        end
    end

    assign tok_out  = tok_reg;
    assign time_out = time_reg;

endmodule

@@ rtl/can_filter_timeout_supervisor_top.sv @@
// CAN acceptance filter with reception-timeout supervision.
//
// Channels: req (sink) takes one command beat: tick, received identifier,
// set slot or remove slot. rsp (source) gives result beats; last_event marks
// the final beat a command causes. Set, remove, a tick with no newly expired
// slot and an unmatched identifier (with some slot valid) give no beat at all.
//
// Each filter slot lives in one cell of a row. An accepted command becomes a
// token that moves one cell per cycle down the row while the row advances;
// each cell applies the command to its own entry. req.ready returns once the
// token has left the last cell; the block works on one command at a time.
// Results leave in slot order; one result is held back so the last one can
// be flagged.
// The token row only advances while the output register is free or being
// taken, so a stalled receiver freezes the row and nothing is lost.
// Reset clears the time counter, all valid and timed-out flags, and the
// handshake state; the block accepts a command in the first cycle after.
module can_filter_timeout_supervisor_top #(
    parameter int FILTER_SLOTS = cfts_pkg::FILTER_SLOTS_DEF,
    parameter int TIME_BITS    = cfts_pkg::TIME_BITS_DEF
) (
    input logic      clk,
    input logic      rst_n,
    cfts_req_if.sink req,
    cfts_rsp_if.source rsp
);
    import cfts_pkg::*;

    tok_t                 tok_reg;
    logic [TIME_BITS-1:0] tim_reg;
    logic [TIME_BITS-1:0] time_now_reg;
    logic                 busy_reg;
    logic                 pend_valid_reg;
    res_t                 pend_reg;
    logic                 out_valid_reg;
    res_t                 out_res_reg;
    logic                 out_last_reg;

    tok_t                 tok_c  [FILTER_SLOTS+1];
    logic [TIME_BITS-1:0] time_c [FILTER_SLOTS+1];
    res_t                 cell_res [FILTER_SLOTS];

    logic accept, adv, fin, rx_empty, push, push_last;
    res_t res_sel, push_res;

    assign req.ready = !busy_reg;
    assign accept    = req.valid && !busy_reg;
    // Advance the row whenever the output register can take a beat
    assign adv       = !out_valid_reg || rsp.ready;

    assign tok_c[0]  = tok_reg;
    assign time_c[0] = tim_reg;

    for (genvar i = 0; i < FILTER_SLOTS; i++)
    begin : g_cell
        cfts_cell #(
            .IDX       (i),
            .TIME_BITS (TIME_BITS)
        ) u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .adv      (adv),
            .tok_in   (tok_c[i]),
            .time_in  (time_c[i]),
            .tok_out  (tok_c[i+1]),
            .time_out (time_c[i+1]),
            .res      (cell_res[i])
        );
    end

    // Only the cell holding the token can report, so pick whichever fires
    always_comb
    begin
        res_sel = '0;
        for (int i = 0; i < FILTER_SLOTS; i++)
        begin
            if (cell_res[i].emit)
            begin
                res_sel = cell_res[i];
            end
        end
    end

    assign fin      = adv && tok_c[FILTER_SLOTS].active;
    assign rx_empty = (tok_c[FILTER_SLOTS].cmd == CMD_RX) && !tok_c[FILTER_SLOTS].any;

    // Release held result on a newer one; at the end flag it last or emit a lone pass
    always_comb
    begin
        push      = 1'b0;
        push_last = 1'b0;
        push_res  = pend_reg;
        if (adv && res_sel.emit && pend_valid_reg)
        begin
            push = 1'b1;
        end
        if (fin)
        begin
            if (pend_valid_reg)
            begin
                push      = 1'b1;
                push_last = 1'b1;
            end
            else if (rx_empty)
            begin
                push               = 1'b1;
                push_last          = 1'b1;
                push_res           = '0;
                push_res.emit      = 1'b1;
                push_res.ev        = EV_PASS;
                push_res.packet_id = tok_c[FILTER_SLOTS].id;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_reg        <= '0;
            time_now_reg   <= '0;
            busy_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                tok_reg.active <= 1'b1;
                tok_reg.cmd    <= cmd_t'(req.cmd);
                tok_reg.id     <= req.can_id;
                tok_reg.mask   <= req.filter_mask;
                tok_reg.slot   <= req.slot;
                tok_reg.tmo    <= req.timeout_ticks;
                tok_reg.found  <= 1'b0;
                tok_reg.any    <= 1'b0;
                if (cmd_t'(req.cmd) == CMD_TICK)
                begin
                    time_now_reg <= time_now_reg + 1'b1;
                end
            end
            else if (adv)
            begin
                tok_reg.active <= 1'b0;
            end

            if (accept)
            begin
                busy_reg <= 1'b1;
            end
            else if (fin)
            begin
                busy_reg <= 1'b0;
            end

            if (adv && res_sel.emit)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (fin)
            begin
                pend_valid_reg <= 1'b0;
            end

            if (push)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tim_reg <= (cmd_t'(req.cmd) == CMD_TICK) ? time_now_reg + 1'b1 : time_now_reg;
        end
        if (adv && res_sel.emit)
        begin
            pend_reg <= res_sel;
        end
        if (push)
        begin
            out_res_reg  <= push_res;
            out_last_reg <= push_last;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.event_res  = out_res_reg.ev;
    assign rsp.hit_slot   = out_res_reg.hit_slot;
    assign rsp.packet_id  = out_res_reg.packet_id;
    assign rsp.recovered  = out_res_reg.recovered;
    assign rsp.last_event = out_last_reg;

`ifndef SYNTHESIS
    a_one_cmd: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("command accepted while another is in flight");
    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.event_res == EV_PASS |-> rsp.last_event)
        else $error("empty-table pass not flagged last");
    a_tmo_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.event_res == EV_TIMEOUT |-> rsp.packet_id == '0 && !rsp.recovered)
        else $error("timeout beat carries identifier or recovery");
    a_idle_out: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> !pend_valid_reg)
        else $error("held result left behind after command finished");
`endif

endmodule
